### hdl/pll_synth_word_builder_top_defines.svh
// Assertion macros used by the port-level checker file.
`ifndef PLL_SYNTH_WORD_BUILDER_TOP_DEFINES_SVH
`define PLL_SYNTH_WORD_BUILDER_TOP_DEFINES_SVH

// Property checked at every edge outside reset.
`define PSWB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PSWB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/pswb_pkg.sv
// Types, constants and word-building functions for the PLL word builder.
package pswb_pkg;

    localparam int FREQ_W   = 32;
    localparam int PFD_W    = 27;
    localparam int RDIV_W   = 14;
    localparam int WORD_W   = 24;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;
    localparam int NUM_CELLS  = FREQ_W;
    localparam int B_W      = 13;
    localparam int A_W      = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REF_DIVIDER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PFD_RATE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER_SEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_OPTIONS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_OPTIONS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CP_GAIN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_N_OPTIONS       = 3'd6;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_REF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CTRL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIV  = 2'd2;

    // control bits in bits 1..0
    localparam logic [1:0] CTL_REF     = 2'b01;
    localparam logic [1:0] CTL_CONTROL = 2'b00;
    localparam logic [1:0] CTL_DIVIDER = 2'b10;

    localparam logic [B_W-1:0] B_MIN = 13'd3;
    localparam logic [B_W-1:0] B_MAX = 13'd8191;
    localparam logic [A_W-1:0] A_MIN = 5'd2;
    localparam logic [A_W-1:0] A_MAX = 5'd31;

    localparam logic [PFD_W-1:0]  RST_PFD_RATE        = 27'd1000000;
    localparam logic [RDIV_W-1:0] RST_REF_DIVIDER     = 14'd1;
    localparam logic [1:0]        RST_PRESCALER_SEL   = 2'd2;
    localparam logic [7:0]        RST_R_OPTIONS       = 8'd3;
    localparam logic [21:0]       RST_CONTROL_OPTIONS = 22'd14628;

    typedef struct packed {
        logic [RDIV_W-1:0] ref_divider;
        logic [PFD_W-1:0]  pfd_rate;
        logic [1:0]        prescaler_sel;
        logic [7:0]        r_options;
        logic [21:0]       control_options;
        logic              cp_gain;
        logic [1:0]        n_options;
    } t_cfg;

    // data handed from one division cell to the next
    typedef struct packed {
        logic              valid;
        logic [PFD_W-1:0]  rem;
        logic [FREQ_W-1:0] work;  // dividend bits shift out, quotient bits shift in
    } t_div_stage;

    function automatic logic [WORD_W-1:0] ref_word(input t_cfg c);
        logic [RDIV_W-1:0] rdiv;
        rdiv = (c.ref_divider == '0) ? RDIV_W'(1) : c.ref_divider;
        return {c.r_options, rdiv, CTL_REF};
    endfunction

    function automatic logic [WORD_W-1:0] ctrl_word(input t_cfg c);
        logic [21:0] body;
        body = {c.control_options[21:2], 2'b00};
        body[10] = body[10] | c.cp_gain;
        return {c.prescaler_sel, body[21:2], CTL_CONTROL};
    endfunction

    function automatic logic [WORD_W-1:0] div_word(input t_cfg c, input logic [FREQ_W-1:0] steps);
        logic [FREQ_W-1:0] b_full;
        logic [5:0]        a_full;
        logic [B_W-1:0]    b;
        logic [A_W-1:0]    a;
        b_full = steps >> (3 + c.prescaler_sel);
        a_full = steps[5:0] & ((6'd8 << c.prescaler_sel) - 6'd1);
        if (b_full < FREQ_W'(B_MIN))      b = B_MIN;
        else if (b_full > FREQ_W'(B_MAX)) b = B_MAX;
        else                              b = b_full[B_W-1:0];
        if (a_full < 6'(A_MIN))      a = A_MIN;
        else if (a_full > 6'(A_MAX)) a = A_MAX;
        else                         a = a_full[A_W-1:0];
        return {c.n_options[1], c.n_options[0], c.cp_gain, b, 1'b0, a, CTL_DIVIDER};
    endfunction

endpackage

### hdl/pswb_div_cell.sv
// One restoring-division cell: resolves one quotient bit per request.
module pswb_div_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic [pswb_pkg::PFD_W-1:0] i_divisor,
    input  pswb_pkg::t_div_stage      i_stage,
    output pswb_pkg::t_div_stage      o_stage
);
    import pswb_pkg::*;

    logic             r_valid;
    logic [PFD_W-1:0] r_rem;
    logic [FREQ_W-1:0] r_work;
    logic [PFD_W:0]   trial;
    logic             ge;
    logic [PFD_W:0]   diff;
    logic [PFD_W-1:0] n_rem;
    logic [FREQ_W-1:0] n_work;

    always_comb begin
        trial  = {i_stage.rem, i_stage.work[FREQ_W-1]};
        ge     = trial >= {1'b0, i_divisor};
        diff   = trial - {1'b0, i_divisor};
        // remainder stays below the divisor, so it fits the narrower width
        n_rem  = ge ? diff[PFD_W-1:0] : trial[PFD_W-1:0];
        n_work = {i_stage.work[FREQ_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_stage = '{valid: r_valid, rem: r_rem, work: r_work};

endmodule

### hdl/pswb_serializer.sv
// Output stage: holds one quotient and sends its three programming words.
module pswb_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pswb_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    input  logic [pswb_pkg::FREQ_W-1:0]   i_steps,
    output logic                          o_load,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pswb_pkg::WORD_W-1:0]   o_reg_word,
    output logic [pswb_pkg::KIND_W-1:0]   o_word_kind,
    output logic                          o_last_word
);
    import pswb_pkg::*;

    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [FREQ_W-1:0] r_steps;
    logic              out_take;

    assign out_take = r_valid && !i_out_stall;
    assign o_load   = !r_valid || (out_take && r_kind == KIND_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kind  <= KIND_REF;
        end else if (o_load) begin
            r_valid <= i_in_valid;
            r_kind  <= KIND_REF;
        end else if (out_take) begin
            r_kind <= (r_kind == KIND_REF) ? KIND_CTRL : KIND_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_steps <= i_steps;
        end
    end

    always_comb begin
        unique case (r_kind)
            KIND_REF:  o_reg_word = ref_word(i_cfg);
            KIND_CTRL: o_reg_word = ctrl_word(i_cfg);
            KIND_DIV:  o_reg_word = div_word(i_cfg, r_steps);
            default:   o_reg_word = '0;
        endcase
    end

    assign o_out_valid = r_valid;
    assign o_word_kind = r_kind;
    assign o_last_word = (r_kind == KIND_DIV);

endmodule

### hdl/pll_synth_word_builder_top.sv
// Top level of the PLL programming-word builder.
// Each request carries an output frequency and yields three 24-bit words: reference,
// control, divider (last flagged). freq_hz / pfd_rate runs through a chain of 32
// restoring-division cells, one quotient bit per cell, so a request passes the 32 cell
// registers and is then loaded into the output stage, which sends the reference word
// first. The chain takes a new request every cycle while it can move; the single output
// port sends one word per cycle while not stalled, three per request. Configuration writes
// are always ready and take effect at once; write them only while the block is idle.
module pll_synth_word_builder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pswb_pkg::FREQ_W-1:0]     i_freq_hz,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pswb_pkg::WORD_W-1:0]     o_reg_word,
    output logic [pswb_pkg::KIND_W-1:0]     o_word_kind,
    output logic                            o_last_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pswb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pswb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pswb_pkg::*;

    t_cfg             r_cfg;
    logic [PFD_W-1:0] divisor;
    t_div_stage       stage [0:NUM_CELLS];
    logic             advance;
    logic             ser_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_divider     <= RST_REF_DIVIDER;
            r_cfg.pfd_rate        <= RST_PFD_RATE;
            r_cfg.prescaler_sel   <= RST_PRESCALER_SEL;
            r_cfg.r_options       <= RST_R_OPTIONS;
            r_cfg.control_options <= RST_CONTROL_OPTIONS;
            r_cfg.cp_gain         <= 1'b0;
            r_cfg.n_options       <= 2'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_REF_DIVIDER:     r_cfg.ref_divider     <= i_cfg_data[RDIV_W-1:0];
                REG_PFD_RATE:        r_cfg.pfd_rate        <= i_cfg_data[PFD_W-1:0];
                REG_PRESCALER_SEL:   r_cfg.prescaler_sel   <= i_cfg_data[1:0];
                REG_R_OPTIONS:       r_cfg.r_options       <= i_cfg_data[7:0];
                REG_CONTROL_OPTIONS: r_cfg.control_options <= i_cfg_data[21:0];
                REG_CP_GAIN:         r_cfg.cp_gain         <= i_cfg_data[0];
                REG_N_OPTIONS:       r_cfg.n_options       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // zero rate divides by one
    assign divisor = (r_cfg.pfd_rate == '0) ? PFD_W'(1) : r_cfg.pfd_rate;

    // whole chain moves together; it holds only when the last cell cannot unload
    assign advance    = !stage[NUM_CELLS].valid || ser_load;
    assign o_in_stall = !advance;

    assign stage[0] = '{valid: i_in_valid, rem: '0, work: i_freq_hz};

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        pswb_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_divisor (divisor),
            .i_stage   (stage[k]),
            .o_stage   (stage[k+1])
        );
    end

    pswb_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (stage[NUM_CELLS].valid),
        .i_steps     (stage[NUM_CELLS].work),
        .o_load      (ser_load),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_reg_word  (o_reg_word),
        .o_word_kind (o_word_kind),
        .o_last_word (o_last_word)
    );

endmodule

### hdl/pswb_checker.sv
// Port-level checker for the PLL word builder, bound to the top level.
`include "pll_synth_word_builder_top_defines.svh"

module pswb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [pswb_pkg::WORD_W-1:0]   o_reg_word,
    input logic [pswb_pkg::KIND_W-1:0]   o_word_kind,
    input logic                          o_last_word
);
    import pswb_pkg::*;

    `PSWB_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_out_valid, "output valid right after reset")

    `PSWB_ASSERT(a_ref_then_ctrl, o_out_valid && !i_out_stall && o_word_kind == KIND_REF |=> o_out_valid && o_word_kind == KIND_CTRL, "control word must follow reference word")

    `PSWB_ASSERT(a_ctrl_then_div, o_out_valid && !i_out_stall && o_word_kind == KIND_CTRL |=> o_out_valid && o_word_kind == KIND_DIV, "divider word must follow control word")

    `PSWB_ASSERT(a_word_tag, o_out_valid |-> (o_last_word == (o_word_kind == KIND_DIV)) && ((o_word_kind == KIND_REF && o_reg_word[1:0] == CTL_REF) || (o_word_kind == KIND_CTRL && o_reg_word[1:0] == CTL_CONTROL) || (o_word_kind == KIND_DIV && o_reg_word[1:0] == CTL_DIVIDER)), "word control bits or last flag mismatch")

    `PSWB_ASSERT(a_stall_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word_kind), "stalled result changed")

endmodule

bind pll_synth_word_builder_top pswb_checker u_pswb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_reg_word  (o_reg_word),
    .o_word_kind (o_word_kind),
    .o_last_word (o_last_word)
);

### dv/pll_synth_word_builder_checker.sv
// Checker for the PLL word builder: predicts the three words of each request and compares.
`timescale 1ns / 1ps

module pll_synth_word_builder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [pswb_pkg::FREQ_W-1:0]     i_freq_hz,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [pswb_pkg::WORD_W-1:0]     i_reg_word,
    input  logic [pswb_pkg::KIND_W-1:0]     i_word_kind,
    input  logic                            i_last_word,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [pswb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pswb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_error_count,
    output int                              o_words_pending,
    output int                              o_words_checked
);
    import pswb_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_prog_word;

    t_cfg       settings;
    t_prog_word expected_words[$];

    initial begin
        o_error_count   = 0;
        o_words_pending = 0;
        o_words_checked = 0;
    end

    // queue the reference, control and divider words for one frequency request
    task automatic queue_prog_words(input logic [FREQ_W-1:0] freq);
        logic [RDIV_W-1:0] rdiv;
        logic [31:0]       divisor, steps, modulus, b_cnt, a_cnt;
        t_prog_word        pw;

        rdiv = (settings.ref_divider == '0) ? RDIV_W'(1) : settings.ref_divider;
        pw.word = {settings.r_options, rdiv, CTL_REF};
        pw.kind = KIND_REF;
        pw.last = 1'b0;
        expected_words.push_back(pw);

        pw.word = {settings.prescaler_sel, settings.control_options[21:2], CTL_CONTROL};
        pw.word[10] = pw.word[10] | settings.cp_gain;
        pw.kind = KIND_CTRL;
        expected_words.push_back(pw);

        divisor = (settings.pfd_rate == '0) ? 32'd1 : 32'(settings.pfd_rate);
        steps   = freq / divisor;
        modulus = 32'd8 << settings.prescaler_sel;
        b_cnt   = steps / modulus;
        // remainder taken before the b clamp
        a_cnt   = steps - b_cnt * modulus;
        if (b_cnt < 32'(B_MIN)) b_cnt = 32'(B_MIN);
        if (b_cnt > 32'(B_MAX)) b_cnt = 32'(B_MAX);
        if (a_cnt < 32'(A_MIN)) a_cnt = 32'(A_MIN);
        if (a_cnt > 32'(A_MAX)) a_cnt = 32'(A_MAX);
        pw.word = {settings.n_options[1], settings.n_options[0], settings.cp_gain,
                   b_cnt[B_W-1:0], 1'b0, a_cnt[A_W-1:0], CTL_DIVIDER};
        pw.kind = KIND_DIV;
        pw.last = 1'b1;
        expected_words.push_back(pw);
    endtask

    always @(posedge i_clk) begin
        t_prog_word pw;
        if (!i_rst_n) begin
            settings.ref_divider     = RST_REF_DIVIDER;
            settings.pfd_rate        = RST_PFD_RATE;
            settings.prescaler_sel   = RST_PRESCALER_SEL;
            settings.r_options       = RST_R_OPTIONS;
            settings.control_options = RST_CONTROL_OPTIONS;
            settings.cp_gain         = 1'b0;
            settings.n_options       = 2'd0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_REF_DIVIDER:     settings.ref_divider     = i_cfg_data[RDIV_W-1:0];
                    REG_PFD_RATE:        settings.pfd_rate        = i_cfg_data[PFD_W-1:0];
                    REG_PRESCALER_SEL:   settings.prescaler_sel   = i_cfg_data[1:0];
                    REG_R_OPTIONS:       settings.r_options       = i_cfg_data[7:0];
                    REG_CONTROL_OPTIONS: settings.control_options = i_cfg_data[21:0];
                    REG_CP_GAIN:         settings.cp_gain         = i_cfg_data[0];
                    REG_N_OPTIONS:       settings.n_options       = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                queue_prog_words(i_freq_hz);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("word %06h kind %0d arrived with nothing expected",
                           i_reg_word, i_word_kind);
                    o_error_count++;
                end else begin
                    pw = expected_words.pop_front();
                    o_words_checked++;
                    if (i_reg_word !== pw.word) begin
                        $error("reg_word: expected %06h, got %06h", pw.word, i_reg_word);
                        o_error_count++;
                    end
                    if (i_word_kind !== pw.kind) begin
                        $error("word_kind: expected %0d, got %0d", pw.kind, i_word_kind);
                        o_error_count++;
                    end
                    if (i_last_word !== pw.last) begin
                        $error("last_word: expected %0b, got %0b", pw.last, i_last_word);
                        o_error_count++;
                    end
                end
            end
        end
        o_words_pending = expected_words.size();
    end

endmodule

### dv/pll_synth_word_builder_top_test.sv
// Testbench top for the PLL word builder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pll_synth_word_builder_top_test;
    import pswb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [FREQ_W-1:0]     freq_hz   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [WORD_W-1:0]     reg_word;
    logic [KIND_W-1:0]     word_kind;
    logic                  last_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int error_count, words_pending, words_checked;
    int tx_idle_pct     = 25;
    int rx_idle_pct     = 71;
    int requests_sent   = 0;
    int settings_used   = 1;
    logic [PFD_W-1:0] cur_pfd       = RST_PFD_RATE;
    logic [1:0]       cur_prescaler = RST_PRESCALER_SEL;

    pll_synth_word_builder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_freq_hz   (freq_hz),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_reg_word  (reg_word),
        .o_word_kind (word_kind),
        .o_last_word (last_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pll_synth_word_builder_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_freq_hz       (freq_hz),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_reg_word      (reg_word),
        .i_word_kind     (word_kind),
        .i_last_word     (last_word),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_error_count   (error_count),
        .o_words_pending (words_pending),
        .o_words_checked (words_checked)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic send_request(input logic [FREQ_W-1:0] freq);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        freq_hz  <= freq;
        do @(posedge i_clk); while (in_stall);
        requests_sent++;
    endtask

    // leaves cfg_valid high; the caller drops it after the last write of a batch
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == REG_PFD_RATE)      cur_pfd       = data[PFD_W-1:0];
        if (idx == REG_PRESCALER_SEL) cur_prescaler = data[1:0];
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] pfd;
        case ($urandom_range(3))
            0: pfd = CFG_DATA_W'($urandom_range(1, 1000));
            1: pfd = CFG_DATA_W'($urandom_range(1, 100000));
            2: pfd = CFG_DATA_W'($urandom_range(1000, 100000000));
            default: pfd = CFG_DATA_W'($urandom);
        endcase
        write_setting(REG_REF_DIVIDER, CFG_DATA_W'($urandom));
        write_setting(REG_PFD_RATE, pfd);
        write_setting(REG_PRESCALER_SEL, CFG_DATA_W'($urandom));
        write_setting(REG_R_OPTIONS, CFG_DATA_W'($urandom));
        write_setting(REG_CONTROL_OPTIONS, CFG_DATA_W'($urandom));
        write_setting(REG_CP_GAIN, CFG_DATA_W'($urandom));
        write_setting(REG_N_OPTIONS, CFG_DATA_W'($urandom));
        if ($urandom_range(3) == 0)
            write_setting(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly frequencies that land the divider counts in their useful range
    task automatic random_requests(input int count);
        logic [63:0]       divisor, hi, steps, f;
        logic [FREQ_W-1:0] freq;
        repeat (count) begin
            divisor = (cur_pfd == '0) ? 64'd1 : 64'(cur_pfd);
            if ($urandom_range(3) == 0) begin
                freq = $urandom;
            end else begin
                hi = 64'hFFFF_FFFF / divisor;
                if (hi > (64'd8 << cur_prescaler) * 64'd8300)
                    hi = (64'd8 << cur_prescaler) * 64'd8300;
                steps = 64'($urandom_range(0, 32'(hi)));
                f = steps * divisor + 64'($urandom_range(0, 32'(divisor - 64'd1)));
                freq = (f > 64'hFFFF_FFFF) ? $urandom : f[31:0];
            end
            send_request(freq);
        end
    endtask

    initial begin
        int failures;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: frequency extremes, b below its floor
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        send_request(32'd100_000_000);
        send_request(32'd37_000_000);
        send_request(32'd2_000_000_000);
        wait_drained();

        // zero reference counter, zero pfd rate, widest modulus, all option bits set
        write_setting(REG_REF_DIVIDER, 27'd0);
        write_setting(REG_PFD_RATE, 27'd0);
        write_setting(REG_PRESCALER_SEL, 27'd3);
        write_setting(REG_R_OPTIONS, 27'd255);
        write_setting(REG_CONTROL_OPTIONS, 27'h3F_FFFF);
        write_setting(REG_CP_GAIN, 27'd1);
        write_setting(REG_N_OPTIONS, 27'd3);
        write_setting(REG_UNUSED, 27'h555_5555);
        cfg_valid <= 1'b0;
        settings_used++;
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        send_request(32'd6440);     // a above 31
        send_request(32'd193);      // a below 2
        send_request(32'd524224);   // b at its ceiling
        send_request(32'd524288);   // b past its ceiling
        wait_drained();

        // oversized write data, only the register width survives
        write_setting(REG_REF_DIVIDER, 27'h7FF_FFFF);
        write_setting(REG_PFD_RATE, 27'h7FF_FFFF);
        write_setting(REG_PRESCALER_SEL, 27'h7FF_FFFC);
        write_setting(REG_R_OPTIONS, 27'h7FF_FF00);
        write_setting(REG_CONTROL_OPTIONS, 27'h7C0_0000);
        write_setting(REG_CP_GAIN, 27'h7FF_FFFE);
        write_setting(REG_N_OPTIONS, 27'd5);
        cfg_valid <= 1'b0;
        settings_used++;
        send_request(32'hFFFF_FFFF);
        send_request(32'd0);
        send_request(32'h8000_0000);
        wait_drained();

        // cp_gain alone sets control bit 10
        write_setting(REG_REF_DIVIDER, 27'd16383);
        write_setting(REG_PFD_RATE, 27'd1);
        write_setting(REG_PRESCALER_SEL, 27'd1);
        write_setting(REG_R_OPTIONS, 27'hA5);
        write_setting(REG_CONTROL_OPTIONS, 27'h3F_FBFF);
        write_setting(REG_CP_GAIN, 27'd1);
        write_setting(REG_N_OPTIONS, 27'd2);
        cfg_valid <= 1'b0;
        settings_used++;
        send_request(32'd131071);
        send_request(32'd47);
        send_request(32'h5555_5555);
        wait_drained();

        random_settings();
        random_requests(31);
        wait_drained();

        tx_idle_pct = 71;
        rx_idle_pct = 25;
        random_settings();
        random_requests(31);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_settings();
        random_requests(31);
        wait_drained();

        repeat (40) @(posedge i_clk);
        failures = error_count + words_pending;
        if (words_pending != 0)
            $error("%0d expected words never arrived", words_pending);
        $display("Covered %0d frequency requests across %0d register settings, %0d words compared.",
                 requests_sent, settings_used, words_checked);
        $display("Handshake idling ran at 25/71, 71/25 and 0/0 percent (sender/receiver).");
        if (failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d words still expected", words_pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
